// File: src/cltok_pkg.sv
// shared types and constants of the command line tokenizer
package cltok_pkg;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // number limits
    localparam logic [31:0] NUM_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [35:0] NUM_SAT     = 36'h0_8000_0000;

    // result queue: room for one full burst of three plus two queued words
    localparam int Q_DEPTH = 5;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int MAX_RES = 3;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_WORD  = 2'd1,
        KIND_VALUE = 2'd2,
        KIND_LINE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WORD   = 3'd1,
        MODE_QUOTE  = 3'd2,
        MODE_MINUS  = 3'd3,
        MODE_NUMBER = 3'd4,
        MODE_FULL   = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
    } t_in_word;

    typedef struct packed {
        t_kind              kind;
        logic [2:0]         token_index;
        logic [4:0]         char_pos;
        logic [7:0]         char_value;
        logic [4:0]         word_length;
        logic signed [31:0] number_value;
        logic [3:0]         word_count;
        logic               last_of_run;
    } t_out_word;

    // results of one processed word, handed from scanner to queue
    typedef struct packed {
        logic [1:0]               count;
        t_out_word [MAX_RES-1:0]  items;
    } t_scan_res;

endpackage

// File: src/cltok_chan_if.sv
// valid/ready channel carrying one payload word
interface cltok_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/command_line_tokenizer.sv
// top level of the command line tokenizer
// a word is held in the input register, scanned, and its results are written into the result queue
// throughput: one word per cycle while the output is ready and each word yields at most one result;
// a word with two or three results sends them one at a time through the single output port
// reset: synchronous active-low reset clears the scanner, the input stage and the queue
module command_line_tokenizer #(
    parameter int MAX_TOKENS  = 8,
    parameter int TOKEN_CHARS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cltok_chan_if.sink   i_in,
    cltok_chan_if.source o_out
);
    import cltok_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in;
    logic      room;
    logic      proc_fire;
    logic      in_take;
    t_scan_res res;

    // input stage handshake
    assign proc_fire = r_in_valid && room;
    assign i_in.ready = !r_in_valid || proc_fire;
    assign in_take    = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_in <= i_in.data;
    end

    cltok_scan #(
        .MAX_TOKENS  (MAX_TOKENS),
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc_fire),
        .i_word  (r_in),
        .o_res   (res)
    );

    cltok_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

// File: src/cltok_scan.sv
// scanner state machine: turns one input word into up to three results
module cltok_scan #(
    parameter int MAX_TOKENS  = 8,
    parameter int TOKEN_CHARS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  cltok_pkg::t_in_word   i_word,
    output cltok_pkg::t_scan_res  o_res
);
    import cltok_pkg::*;

    localparam int WW = $clog2(MAX_TOKENS + 1);
    localparam int CW = $clog2(TOKEN_CHARS);
    localparam logic [CW-1:0] CIDX_MAX  = CW'(TOKEN_CHARS - 1);
    localparam logic [WW-1:0] WORDS_MAX = WW'(MAX_TOKENS);

    t_mode          r_mode, n_mode;
    logic [WW-1:0]  r_words, n_words;
    logic [CW-1:0]  r_cidx, n_cidx;
    logic [31:0]    r_acc, n_acc;
    logic           r_neg, n_neg;
    logic           r_done, n_done;
    t_scan_res      res;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic void push(inout t_scan_res s, input t_out_word w);
        s.items[s.count] = w;
        s.count = s.count + 2'd1;
    endfunction

    function automatic void add_char(inout t_scan_res s, inout logic [CW-1:0] cidx,
                                     input logic [WW-1:0] words, input logic [7:0] c);
        t_out_word w;
        w = '0;
        if (cidx < CIDX_MAX) begin
            w.kind        = KIND_CHAR;
            w.token_index = 3'(words);
            w.char_pos    = 5'(cidx);
            w.char_value  = c;
            push(s, w);
            cidx = cidx + 1'b1;
        end
    endfunction

    function automatic void finish_word(inout t_scan_res s, inout logic [CW-1:0] cidx,
                                        inout logic [WW-1:0] words, output t_mode mode);
        t_out_word w;
        w = '0;
        w.kind        = KIND_WORD;
        w.token_index = 3'(words);
        w.word_length = 5'(cidx);
        push(s, w);
        words = words + 1'b1;
        cidx  = '0;
        mode  = (words >= WORDS_MAX) ? MODE_FULL : MODE_IDLE;
    endfunction

    function automatic void finish_number(inout t_scan_res s, input logic [WW-1:0] words,
                                          input logic [31:0] acc, input logic neg);
        t_out_word w;
        w = '0;
        w.kind        = KIND_VALUE;
        w.token_index = (words != '0) ? 3'(words - 1'b1) : 3'd0;
        if (neg) begin
            w.number_value = 32'd0 - acc;
        end else begin
            w.number_value = (acc > NUM_POS_MAX) ? NUM_POS_MAX : acc;
        end
        push(s, w);
    endfunction

    // accumulator times ten plus digit, saturating at two to the 31
    function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] c);
        logic [35:0] a;
        a = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {28'd0, c - CH_ZERO};
        return (a > NUM_SAT) ? NUM_SAT[31:0] : a[31:0];
    endfunction

    // next state and results
    always_comb begin
        t_out_word lw;
        logic      sep;
        logic [7:0] c;
        n_mode  = r_mode;
        n_words = r_words;
        n_cidx  = r_cidx;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_done  = r_done;
        res     = '0;
        lw      = '0;
        c       = i_word.char_byte;
        sep     = (c == CH_SPACE) || (c == CH_NUL);
        if (i_fire) begin
            if (i_word.line_end) begin
                unique case (r_mode) inside
                    MODE_WORD, MODE_QUOTE: begin
                        if (n_cidx != '0) finish_word(res, n_cidx, n_words, n_mode);
                    end
                    MODE_NUMBER: finish_number(res, n_words, n_acc, n_neg);
                    MODE_MINUS: begin
                        add_char(res, n_cidx, n_words, CH_MINUS);
                        finish_word(res, n_cidx, n_words, n_mode);
                    end
                    default: ;
                endcase
                lw.kind       = KIND_LINE;
                lw.word_count = 4'(n_words);
                push(res, lw);
                n_mode  = MODE_IDLE;
                n_words = '0;
                n_cidx  = '0;
                n_acc   = '0;
                n_neg   = 1'b0;
                n_done  = 1'b0;
            end else begin
                unique case (r_mode)
                    MODE_WORD: begin
                        if (sep) finish_word(res, n_cidx, n_words, n_mode);
                        else     add_char(res, n_cidx, n_words, c);
                    end
                    MODE_QUOTE: begin
                        if (c == CH_QUOTE || c == CH_NUL) begin
                            if (n_cidx != '0) finish_word(res, n_cidx, n_words, n_mode);
                            else              n_mode = MODE_IDLE;
                        end else begin
                            add_char(res, n_cidx, n_words, c);
                        end
                    end
                    MODE_MINUS: begin
                        if (is_digit(c)) begin
                            n_mode = MODE_NUMBER;
                            n_acc  = add_digit(n_acc, c);
                        end else begin
                            // lone minus turns into an ordinary word
                            n_mode = MODE_WORD;
                            n_cidx = '0;
                            add_char(res, n_cidx, n_words, CH_MINUS);
                            if (sep) finish_word(res, n_cidx, n_words, n_mode);
                            else     add_char(res, n_cidx, n_words, c);
                        end
                    end
                    MODE_NUMBER: begin
                        if (sep) begin
                            finish_number(res, n_words, n_acc, n_neg);
                            n_mode = MODE_IDLE;
                        end else if (is_digit(c) && !n_done) begin
                            n_acc = add_digit(n_acc, c);
                        end else begin
                            n_done = 1'b1;
                        end
                    end
                    MODE_FULL: ;
                    default: begin
                        // start of a new token
                        n_mode = MODE_IDLE;
                        n_cidx = '0;
                        if (sep) begin
                            n_mode = MODE_IDLE;
                        end else if (c == CH_QUOTE) begin
                            n_mode = MODE_QUOTE;
                        end else if (n_words != '0 && (is_digit(c) || c == CH_MINUS)) begin
                            n_done = 1'b0;
                            n_neg  = (c == CH_MINUS);
                            if (c == CH_MINUS) begin
                                n_mode = MODE_MINUS;
                                n_acc  = '0;
                            end else begin
                                n_mode = MODE_NUMBER;
                                n_acc  = add_digit(32'd0, c);
                            end
                        end else begin
                            n_mode = MODE_WORD;
                            add_char(res, n_cidx, n_words, c);
                        end
                    end
                endcase
            end
            if (res.count != 2'd0) res.items[res.count - 2'd1].last_of_run = 1'b1;
        end
    end

    assign o_res = res;

    // scanner state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_words <= '0;
            r_cidx  <= '0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_words <= n_words;
            r_cidx  <= n_cidx;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_done  <= n_done;
        end
    end

endmodule

// File: src/cltok_outq.sv
// result queue: takes up to three results a cycle, sends one word a cycle while the output is ready
module cltok_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cltok_pkg::t_scan_res i_push,
    output logic                 o_room,
    cltok_chan_if.source         o_out
);
    import cltok_pkg::*;

    t_out_word [Q_DEPTH-1:0] r_q, n_q;
    logic [Q_CNT_W-1:0]      r_count, n_count;
    logic [Q_CNT_W-1:0]      base;
    logic                    pop;

    assign pop         = o_out.valid && o_out.ready;
    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_q[0];
    // room for a full burst, judged on the registered fill level
    assign o_room      = (r_count <= Q_CNT_W'(Q_DEPTH - MAX_RES));

    // shift out the head, then append the new results
    always_comb begin
        n_q  = r_q;
        base = r_count - Q_CNT_W'(pop);
        if (pop) begin
            for (int j = 0; j < Q_DEPTH - 1; j++) n_q[j] = r_q[j + 1];
        end
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < i_push.count) n_q[Q_IDX_W'(base + Q_CNT_W'(i))] = i_push.items[i];
        end
        n_count = base + Q_CNT_W'(i_push.count);
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// File: dv/tb_command_line_tokenizer.sv
// self-checking testbench of the command line tokenizer: scripted and random lines
`timescale 1ns / 1ps

module tb_command_line_tokenizer;
    import cltok_pkg::*;

    localparam int MAX_TOKENS   = 8;
    localparam int TOKEN_CHARS  = 32;
    localparam int TOTAL_ITEMS  = 410;
    localparam int IDLE_PCT     = 26;
    localparam int CALM_FIRST   = 300;
    localparam int CALM_LAST    = 520;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_REPORTS  = 30;

    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_LOW_K = 8'h6B;

    logic i_clk;
    logic i_rst_n;

    cltok_chan_if #(.T(t_in_word))  in_ch ();
    cltok_chan_if #(.T(t_out_word)) out_ch ();

    command_line_tokenizer #(
        .MAX_TOKENS  (MAX_TOKENS),
        .TOKEN_CHARS (TOKEN_CHARS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // line bytes waiting to be sent, results still owed by the block
    t_in_word  line_bytes[$];
    t_out_word expected_results[$];
    t_out_word byte_results[$];

    int unsigned fault_count  = 0;
    int unsigned cycle_no     = 0;
    int unsigned stall_cycles = 0;

    // scanner state of the predictor
    t_mode       scan_st   = MODE_IDLE;
    int unsigned n_words   = 0;
    int unsigned n_chars   = 0;
    logic [31:0] num_mag   = '0;
    bit          num_neg   = 1'b0;
    bit          num_stop  = 1'b0;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic log_mismatch(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    function automatic bit take_break();
        if (cycle_no >= CALM_FIRST && cycle_no < CALM_LAST) begin
            return 1'b0;
        end
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // one result of the current input word
    function automatic void put_result(input t_kind k, input int unsigned tok,
                                       input int unsigned pos, input logic [7:0] ch,
                                       input int unsigned len, input logic [31:0] val,
                                       input int unsigned cnt);
        t_out_word r;
        r.kind         = k;
        r.token_index  = tok[2:0];
        r.char_pos     = pos[4:0];
        r.char_value   = ch;
        r.word_length  = len[4:0];
        r.number_value = val;
        r.word_count   = cnt[3:0];
        r.last_of_run  = 1'b0;
        byte_results.push_back(r);
    endfunction

    // characters past the storage limit vanish without a result
    function automatic void add_chr(input logic [7:0] c);
        if (n_chars < TOKEN_CHARS - 1) begin
            put_result(KIND_CHAR, n_words, n_chars, c, 0, '0, 0);
            n_chars++;
        end
    endfunction

    function automatic void close_word();
        put_result(KIND_WORD, n_words, 0, '0, n_chars, '0, 0);
        n_words++;
        n_chars = 0;
        scan_st = (n_words >= MAX_TOKENS) ? MODE_FULL : MODE_IDLE;
    endfunction

    // value goes to the previous word, magnitude saturated
    function automatic void close_value();
        logic [31:0] v;
        if (num_neg) begin
            v = 32'd0 - num_mag;
        end else begin
            v = (num_mag > NUM_POS_MAX) ? NUM_POS_MAX : num_mag;
        end
        put_result(KIND_VALUE, (n_words != 0) ? n_words - 1 : 0, 0, '0, 0, v, 0);
        scan_st = MODE_IDLE;
    endfunction

    function automatic void push_digit(input logic [7:0] c);
        longint unsigned a;
        a = longint'(num_mag) * 10 + longint'(c - CH_ZERO);
        num_mag = (a > 64'h8000_0000) ? 32'h8000_0000 : a[31:0];
    endfunction

    // predict the results of one accepted input word
    function automatic void tokenize_byte(input t_in_word w);
        logic [7:0] c;
        bit         sep;
        t_out_word  r;
        c   = w.char_byte;
        sep = (c == CH_SPACE || c == CH_NUL);
        byte_results.delete();
        if (w.line_end) begin
            case (scan_st)
                MODE_WORD, MODE_QUOTE: begin
                    if (n_chars > 0) close_word();
                end
                MODE_NUMBER: close_value();
                MODE_MINUS: begin
                    add_chr(CH_MINUS);
                    close_word();
                end
                default: ;
            endcase
            put_result(KIND_LINE, 0, 0, '0, 0, '0, n_words);
            scan_st  = MODE_IDLE;
            n_words  = 0;
            n_chars  = 0;
            num_mag  = '0;
            num_neg  = 1'b0;
            num_stop = 1'b0;
        end else begin
            case (scan_st)
                MODE_WORD: begin
                    if (sep) close_word();
                    else add_chr(c);
                end
                MODE_QUOTE: begin
                    if (c == CH_QUOTE || c == CH_NUL) begin
                        // empty quotes leave no word
                        if (n_chars > 0) close_word();
                        else scan_st = MODE_IDLE;
                    end else begin
                        add_chr(c);
                    end
                end
                MODE_MINUS: begin
                    if (is_digit(c)) begin
                        scan_st = MODE_NUMBER;
                        push_digit(c);
                    end else begin
                        // held-back minus turns out to start a word
                        scan_st = MODE_WORD;
                        n_chars = 0;
                        add_chr(CH_MINUS);
                        if (sep) close_word();
                        else add_chr(c);
                    end
                end
                MODE_NUMBER: begin
                    if (sep) close_value();
                    else if (is_digit(c) && !num_stop) push_digit(c);
                    else num_stop = 1'b1;
                end
                MODE_FULL: ;
                default: begin
                    // start of a token
                    scan_st = MODE_IDLE;
                    n_chars = 0;
                    if (sep) begin
                    end else if (c == CH_QUOTE) begin
                        scan_st = MODE_QUOTE;
                    end else if (n_words > 0 && (is_digit(c) || c == CH_MINUS)) begin
                        num_mag  = '0;
                        num_stop = 1'b0;
                        num_neg  = (c == CH_MINUS);
                        if (num_neg) begin
                            scan_st = MODE_MINUS;
                        end else begin
                            scan_st = MODE_NUMBER;
                            push_digit(c);
                        end
                    end else begin
                        scan_st = MODE_WORD;
                        add_chr(c);
                    end
                end
            endcase
        end
        if (byte_results.size() != 0) begin
            r = byte_results.pop_back();
            r.last_of_run = 1'b1;
            byte_results.push_back(r);
        end
        foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
    endfunction

    task automatic push_char(input logic [7:0] c);
        t_in_word w;
        w.char_byte = c;
        w.line_end  = 1'b0;
        line_bytes.push_back(w);
    endtask

    task automatic push_line_end(input logic [7:0] c);
        t_in_word w;
        w.char_byte = c;
        w.line_end  = 1'b1;
        line_bytes.push_back(w);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i]);
        end
    endtask

    // input side: one word offered at a time, held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                tokenize_byte(in_ch.data);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (line_bytes.size() != 0 && !take_break()) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= line_bytes.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each taken word with the oldest prediction
    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        string     diffs;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_results.size() == 0) begin
                    log_mismatch($sformatf("result with none expected: %h", got));
                end else begin
                    want  = expected_results.pop_front();
                    diffs = "";
                    if (got.kind !== want.kind) diffs = {diffs, " kind"};
                    if (got.token_index !== want.token_index) diffs = {diffs, " token_index"};
                    if (got.char_pos !== want.char_pos) diffs = {diffs, " char_pos"};
                    if (got.char_value !== want.char_value) diffs = {diffs, " char_value"};
                    if (got.word_length !== want.word_length) diffs = {diffs, " word_length"};
                    if (got.number_value !== want.number_value) diffs = {diffs, " number_value"};
                    if (got.word_count !== want.word_count) diffs = {diffs, " word_count"};
                    if (got.last_of_run !== want.last_of_run) diffs = {diffs, " last_of_run"};
                    if (diffs != "") begin
                        log_mismatch($sformatf("mismatch in%s: got %h want %h",
                                               diffs, got, want));
                    end
                end
            end
            out_ch.ready <= !take_break();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned n_tok;
        int unsigned len;
        int unsigned pick;
        i_rst_n <= 1'b0;

        // words, negative value, minus before a letter, digits cut by a letter
        push_text("a -12 -x 3q\"5 ");
        push_line_end(8'h41);
        // empty quotes, quote closed by a zero byte, quoted word run into a word, top byte
        push_text("\"\" \"p");
        push_char(CH_NUL);
        push_text("\"r\"s");
        push_char(8'hFF);
        push_text(" -");
        push_line_end(8'hFF);
        // quote left open at the end of the line
        push_text("\"u");
        push_line_end(CH_NUL);

        // random lines built from plausible tokens with some noise
        while (line_bytes.size() < TOTAL_ITEMS) begin
            n_tok = $urandom_range(0, 11);
            for (int t = 0; t < n_tok; t++) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    len = ($urandom_range(99) < 5) ? $urandom_range(30, 36)
                                                   : $urandom_range(1, 6);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(99) < 12) push_char(8'($urandom_range(1, 255)));
                        else push_char(rand_letter());
                    end
                end else if (pick < 60) begin
                    push_char(CH_QUOTE);
                    len = $urandom_range(0, 5);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(99) < 20) push_char(CH_SPACE);
                        else push_char(rand_letter());
                    end
                    pick = $urandom_range(99);
                    if (pick < 80) push_char(CH_QUOTE);
                    else if (pick < 90) push_char(CH_NUL);
                end else if (pick < 85) begin
                    if ($urandom_range(1) != 0) push_char(CH_MINUS);
                    len = ($urandom_range(99) < 6) ? $urandom_range(10, 12)
                                                   : $urandom_range(1, 3);
                    for (int i = 0; i < len; i++) begin
                        push_char(8'(CH_ZERO + $urandom_range(9)));
                    end
                    if ($urandom_range(99) < 20) begin
                        push_char(($urandom_range(1) != 0) ? CH_QUOTE : CH_LOW_K);
                        push_char(8'(CH_ZERO + $urandom_range(9)));
                    end
                end else if (pick < 92) begin
                    push_char(CH_MINUS);
                    if ($urandom_range(1) != 0) push_char(rand_letter());
                end else begin
                    push_char(8'($urandom_range(0, 255)));
                end
                // separator after the token
                pick = $urandom_range(99);
                if (pick < 75) begin
                    push_char(CH_SPACE);
                end else if (pick < 88) begin
                    push_char(CH_SPACE);
                    push_char(CH_SPACE);
                end else begin
                    push_char(CH_NUL);
                end
            end
            push_line_end(8'($urandom_range(0, 255)));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (line_bytes.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            log_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (fault_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
